// File: hw/rtl/pts_pkg.sv
package pts_pkg;

  localparam int TASK_SLOTS = 10;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int STEP_W = $clog2(TASK_SLOTS + 1);

  localparam logic [1:0] KIND_REGISTER = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_REORDER = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [15:0] countdown;
    logic [15:0] period;
    logic [7:0]  prio;
    logic [3:0]  ident;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic pair_left;
    logic pair_right;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/pts_ifs.sv
interface pts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] period;
  logic [7:0]  prio;

  modport source (output valid, kind, period, prio, input ready);
  modport sink (input valid, kind, period, prio, output ready);
endinterface

interface pts_fire_if;
  logic       valid;
  logic       ready;
  logic [3:0] task_id;
  logic       last;

  modport source (output valid, task_id, last, input ready);
  modport sink (input valid, task_id, last, output ready);
endinterface

// File: hw/rtl/periodic_task_tick_scheduler.sv
// Channel  Role    Payload
// req      sink    kind[1:0], period[15:0], prio[7:0]
// fire     source  task_id[3:0], last
//
// A tick rotates the row of task cells once around, one cell per cycle while fire does not
// stall it. A reorder runs TASK_SLOTS odd-even exchange rounds between neighboring cells,
// one per cycle. The block takes a new req transfer only between items. Reset clears the
// task count, the cell valid flags and the output valid flag.
module periodic_task_tick_scheduler (
  input  logic     clk,
  input  logic     rst,
  pts_req_if.sink  req,
  pts_fire_if.source fire
);

  localparam int N = pts_pkg::TASK_SLOTS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_SORT = 3'b100
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [pts_pkg::CNT_W-1:0]  used;
  logic [pts_pkg::STEP_W-1:0] step;
  logic [pts_pkg::STEP_W-1:0] step_next;
  logic                       pend_valid;
  logic                       pend_valid_next;
  logic [3:0]                 pend_id;
  logic [3:0]                 pend_id_next;
  logic                       out_valid;
  logic [3:0]                 out_id;
  logic                       out_last;
  logic                       push;
  logic [3:0]                 push_id;
  logic                       push_last;
  logic                       accept;
  logic                       do_load;
  logic                       rotate;
  logic                       phase;
  logic                       out_free;
  logic                       head_fire;
  logic                       walk_done;

  pts_pkg::entry_t            cells [N];
  pts_pkg::entry_t            head_updated;
  pts_pkg::entry_t            load_entry;
  pts_pkg::entry_t            empty_entry;

  assign req.ready = (state == ST_IDLE);
  assign accept = req.valid && req.ready;
  assign do_load = accept && (req.kind == pts_pkg::KIND_REGISTER) &&
                   (used < pts_pkg::CNT_W'(N));
  assign out_free = !out_valid || fire.ready;
  assign phase = step[0];
  assign walk_done = (step == pts_pkg::STEP_W'(N));
  assign head_fire = cells[0].valid && (cells[0].countdown == 16'd0);

  assign load_entry.valid = 1'b1;
  assign load_entry.countdown = 16'd0;
  assign load_entry.period = req.period;
  assign load_entry.prio = req.prio;
  assign load_entry.ident = 4'(used);

  assign empty_entry = '0;

  always_comb begin
    head_updated = cells[0];
    head_updated.countdown = head_fire ? cells[0].period : (cells[0].countdown - 16'd1);
  end

  always_comb begin
    state_next = state;
    step_next = step;
    pend_valid_next = pend_valid;
    pend_id_next = pend_id;
    push = 1'b0;
    push_id = pend_id;
    push_last = 1'b0;
    rotate = 1'b0;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (accept && req.kind == pts_pkg::KIND_TICK) begin
          state_next = ST_TICK;
        end else if (accept && req.kind == pts_pkg::KIND_REORDER) begin
          state_next = ST_SORT;
        end
      end
      ST_TICK: begin
        if (!walk_done) begin
          if (!(head_fire && pend_valid && !out_free)) begin
            rotate = 1'b1;
            step_next = step + 1'b1;
            if (head_fire) begin
              push = pend_valid;
              pend_valid_next = 1'b1;
              pend_id_next = cells[0].ident;
            end
          end
        end else if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push = 1'b1;
          push_last = 1'b1;
          pend_valid_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_SORT: begin
        step_next = step + 1'b1;
        if (step == pts_pkg::STEP_W'(N - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    pts_pkg::cell_ctrl_t ctrl;
    pts_pkg::entry_t     left_in;
    pts_pkg::entry_t     right_in;

    assign ctrl.load = do_load && (used == pts_pkg::CNT_W'(i));
    assign ctrl.rotate = rotate;
    assign ctrl.pair_right = (state == ST_SORT) && (phase == 1'(i % 2)) && (i + 1 < N);
    assign ctrl.pair_left = (state == ST_SORT) && (phase != 1'(i % 2)) && (i > 0);

    if (i == 0) begin : g_first
      assign left_in = empty_entry;
    end else begin : g_inner_left
      assign left_in = cells[i - 1];
    end

    if (i == N - 1) begin : g_last
      assign right_in = head_updated;
    end else begin : g_inner_right
      assign right_in = cells[i + 1];
    end

    pts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_entry(load_entry),
      .left      (left_in),
      .right     (right_in),
      .entry     (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used <= '0;
      step <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      pend_valid <= pend_valid_next;
      if (do_load) begin
        used <= used + 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (fire.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id <= pend_id_next;
    if (push) begin
      out_id <= push_id;
      out_last <= push_last;
    end
  end

  assign fire.valid = out_valid;
  assign fire.task_id = out_id;
  assign fire.last = out_last;

endmodule

// File: hw/rtl/pts_cell.sv
module pts_cell (
  input  logic                clk,
  input  logic                rst,
  input  pts_pkg::cell_ctrl_t ctrl,
  input  pts_pkg::entry_t     load_entry,
  input  pts_pkg::entry_t     left,
  input  pts_pkg::entry_t     right,
  output pts_pkg::entry_t     entry
);

  pts_pkg::entry_t entry_next;
  logic            swap_right;
  logic            swap_left;

  // A swap moves the higher priority value rightward; equal values stay put.
  assign swap_right = entry.valid && right.valid && (entry.prio > right.prio);
  assign swap_left = left.valid && entry.valid && (left.prio > entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.load) begin
      entry_next = load_entry;
    end else if (ctrl.rotate) begin
      entry_next = right;
    end else if (ctrl.pair_right && swap_right) begin
      entry_next = right;
    end else if (ctrl.pair_left && swap_left) begin
      entry_next = left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    entry.countdown <= entry_next.countdown;
    entry.period <= entry_next.period;
    entry.prio <= entry_next.prio;
    entry.ident <= entry_next.ident;
  end

endmodule

// File: verif/periodic_task_tick_scheduler_test.sv
module periodic_task_tick_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4 * pts_pkg::TASK_SLOTS + 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [15:0] countdown;
    logic [15:0] period;
    logic [7:0]  prio;
    logic [3:0]  ident;
  } task_slot_t;

  typedef struct packed {
    logic [3:0] task_id;
    logic       last;
  } firing_t;

  logic clk;
  logic rst;

  pts_req_if  req_ch();
  pts_fire_if fire_ch();

  periodic_task_tick_scheduler i_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .fire (fire_ch)
  );

  task_slot_t sched_table [pts_pkg::TASK_SLOTS];
  int         task_count;
  firing_t    pending_firings [$];

  int src_idle_pct;
  int sink_idle_pct;
  int fire_hold_cycles;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    fire_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (fire_hold_cycles > 0) begin
        fire_ch.ready = 1'b0;
        fire_hold_cycles--;
      end else begin
        fire_ch.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Expected firings are produced in the order the table is walked on each tick.
  task automatic advance_schedule(input logic [1:0] kind, input logic [15:0] period,
                                  input logic [7:0] prio);
    firing_t    fired [$];
    task_slot_t moving;
    int         j;
    case (kind)
      pts_pkg::KIND_REGISTER: begin
        if (task_count < pts_pkg::TASK_SLOTS) begin
          sched_table[task_count].countdown = 16'd0;
          sched_table[task_count].period = period;
          sched_table[task_count].prio = prio;
          sched_table[task_count].ident = task_count[3:0];
          task_count++;
        end
      end
      pts_pkg::KIND_TICK: begin
        for (int i = 0; i < task_count; i++) begin
          if (sched_table[i].countdown == 16'd0) begin
            fired.push_back('{task_id: sched_table[i].ident, last: 1'b0});
            sched_table[i].countdown = sched_table[i].period;
          end else begin
            sched_table[i].countdown = sched_table[i].countdown - 16'd1;
          end
        end
        if (fired.size() > 0) begin
          fired[fired.size() - 1].last = 1'b1;
        end
        foreach (fired[k]) begin
          pending_firings.push_back(fired[k]);
        end
      end
      pts_pkg::KIND_REORDER: begin
        for (int i = 1; i < task_count; i++) begin
          moving = sched_table[i];
          j = i;
          while (j > 0 && sched_table[j - 1].prio > moving.prio) begin
            sched_table[j] = sched_table[j - 1];
            j--;
          end
          sched_table[j] = moving;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [15:0] period,
                           input logic [7:0] prio);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.kind = kind;
    req_ch.period = period;
    req_ch.prio = prio;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    advance_schedule(kind, period, prio);
    @(negedge clk);
    req_ch.valid = 1'b0;
    req_ch.kind = $urandom;
    req_ch.period = $urandom;
    req_ch.prio = $urandom;
  endtask

  task automatic wait_for_drain();
    while (pending_firings.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    firing_t want;
    if (!rst && fire_ch.valid && fire_ch.ready) begin
      if (pending_firings.size() == 0) begin
        $display("%0t: unexpected firing, expected none, actual task_id %0d last %0d",
                 $time, fire_ch.task_id, fire_ch.last);
        mismatch_count++;
      end else begin
        want = pending_firings.pop_front();
        if (fire_ch.task_id !== want.task_id) begin
          $display("%0t: task_id mismatch, expected %0d, actual %0d",
                   $time, want.task_id, fire_ch.task_id);
          mismatch_count++;
        end
        if (fire_ch.last !== want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, fire_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(pts_pkg::KIND_TICK, 16'hFFFF, 8'hFF);
    send_item(pts_pkg::KIND_REORDER, 16'h0000, 8'h00);
    send_item(KIND_UNUSED, 16'h1234, 8'h56);
  endtask

  // Covers period zero and maximum, equal priorities, reordering, and a full table.
  task automatic test_register_and_tick();
    send_item(pts_pkg::KIND_REGISTER, 16'd0, 8'd255);
    send_item(pts_pkg::KIND_REGISTER, 16'hFFFF, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_REGISTER, 16'd1, 8'd128);
    send_item(pts_pkg::KIND_REGISTER, 16'd2, 8'd128);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_REGISTER, 16'd3, 8'd0);
    send_item(pts_pkg::KIND_REGISTER, 16'd0, 8'd128);
    send_item(pts_pkg::KIND_REORDER, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_REGISTER, 16'd5, 8'd7);
    send_item(pts_pkg::KIND_REGISTER, 16'hAAAA, 8'h55);
    send_item(pts_pkg::KIND_REGISTER, 16'h5555, 8'hAA);
    send_item(pts_pkg::KIND_REGISTER, 16'd4, 8'd255);
    send_item(pts_pkg::KIND_REGISTER, 16'd9, 8'd9);
    send_item(pts_pkg::KIND_REORDER, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    send_item(KIND_UNUSED, 16'd0, 8'd0);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int item_goal);
    int          counted;
    int unsigned pick;
    logic [15:0] rnd_period;
    logic [7:0]  rnd_prio;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    counted = 0;
    while (counted < item_goal) begin
      pick = $urandom_range(99);
      rnd_period = $urandom;
      rnd_prio = $urandom;
      if (pick < 75) begin
        send_item(pts_pkg::KIND_TICK, rnd_period, rnd_prio);
      end else if (pick < 85) begin
        send_item(pts_pkg::KIND_REORDER, rnd_period, rnd_prio);
      end else if (pick < 95) begin
        send_item(pts_pkg::KIND_REGISTER, rnd_period, rnd_prio);
      end else begin
        send_item(KIND_UNUSED, rnd_period, rnd_prio);
      end
      counted++;
    end
    wait_for_drain();
  endtask

  // The receiver stalls long enough for the block to fill up and hold off its input.
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    fire_hold_cycles = HOLD_OFF_CYCLES;
    repeat (30) send_item(pts_pkg::KIND_TICK, 16'd0, 8'd0);
    wait_for_drain();
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = pts_pkg::KIND_REGISTER;
    req_ch.period = 16'd0;
    req_ch.prio = 8'd0;
    task_count = 0;
    mismatch_count = 0;
    fire_hold_cycles = 0;
    src_idle_pct = 34;
    sink_idle_pct = 54;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_register_and_tick();
    wait_for_drain();
    test_random_traffic(34, 54, 100);
    test_random_traffic(54, 34, 100);
    test_random_traffic(0, 0, 100);
    test_backpressure();

    if (mismatch_count == 0 && pending_firings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
